FILE: design/bpt_pkg.sv
// shared types and constants of the per-key top-n score table
package bpt_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 16;

   localparam int KEY_W   = 16;
   localparam int SCORE_W = 32;
   localparam int LEVEL_W = 8;
   localparam int STAMP_W = 32;
   localparam int RANK_W  = 4;
   localparam int COUNT_W = 5;
   localparam int OP_W    = 2;

   localparam logic [OP_W-1:0] OP_OFFER = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [KEY_W-1:0]   user_key;
      logic [SCORE_W-1:0] score_value;
      logic [LEVEL_W-1:0] level_value;
      logic [STAMP_W-1:0] stamp_value;
      logic [RANK_W-1:0]  rank_index;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic [RANK_W-1:0]  insert_rank;
      logic [COUNT_W-1:0] entry_count;
      logic               entry_valid;
      logic [KEY_W-1:0]   entry_key;
      logic [SCORE_W-1:0] entry_score;
      logic [LEVEL_W-1:0] entry_level;
      logic [STAMP_W-1:0] entry_stamp;
   } rsp_type;

   // one stored table row
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [SCORE_W-1:0] score;
      logic [LEVEL_W-1:0] level;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

FILE: design/bpt_ram.sv
// generic single-write single-read ram with registered read data
module bpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/best_per_key_topn_table.sv
// top level of the per-key top-n score table with its scan and shift sequencer
//
//  channel | ports                           | direction | moves
//  --------+---------------------------------+-----------+-------------------------
//  req     | req_valid, req_ready, req_payload | in      | one request per handshake
//  rsp     | rsp_valid, rsp_ready, rsp_payload | out     | one result per request
//
// offer: idle, a scan of count entries through the ram read port, decide,
//   a move pass of up to depth - 1 entries sharing the ram read and write
//   ports (one entry a cycle), place and result; a turned-away offer goes
//   from decide straight to result
// read: idle, fetch and load around the registered ram read, then result;
//   a rank past the count skips fetch and load; clear and unused code: idle, result
// reset clears the entry count, the result valid and the sequencer only, rows are never cleared
// req_ready is high only while idle; a pending result waits in the output
//   register, so the next request is taken while rsp_ready is low
module best_per_key_topn_table
   import bpt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   // index and count widths follow the depth
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int XW = (CW > RANK_W) ? CW : RANK_W;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_SCAN   = 8'b00000010,
      ST_DECIDE = 8'b00000100,
      ST_SHIFT  = 8'b00001000,
      ST_PLACE  = 8'b00010000,
      ST_FETCH  = 8'b00100000,
      ST_LOAD   = 8'b01000000,
      ST_RESP   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   req_type req_ff, req_in;

   // scan bookkeeping
   logic [CW-1:0] scan_addr_ff, scan_addr_in;
   logic chk_ff, chk_in;
   logic [CW-1:0] chk_idx_ff, chk_idx_in;
   logic match_ff, match_in;
   logic hi_ff, hi_in;
   logic [CW-1:0] match_idx_ff, match_idx_in;
   logic pos_found_ff, pos_found_in;
   logic [CW-1:0] pos_ff, pos_in;

   // move pass
   logic [CW-1:0] sh_ff, sh_in;
   logic pend_ff, pend_in;
   logic [CW-1:0] pend_dst_ff, pend_dst_in;

   // result bookkeeping
   logic acc_ff, acc_in;
   logic ent_vld_ff, ent_vld_in;
   entry_type rdent_ff, rdent_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // ram ports
   logic ram_wr_en;
   logic [IW-1:0] ram_wr_addr;
   entry_type ram_wr_data;
   logic [IW-1:0] ram_rd_addr;
   entry_type ram_rd_data;

   logic [CW-1:0] top_idx;

   bpt_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_rows (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // last row touched by the move pass: the old row of the key, else the tail
   always_comb begin
      if (match_ff) begin
         top_idx = match_idx_ff;
      end else if (count_ff < CW'(TABLE_DEPTH)) begin
         top_idx = count_ff;
      end else begin
         top_idx = CW'(TABLE_DEPTH - 1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      req_in       = req_ff;
      scan_addr_in = scan_addr_ff;
      chk_in       = 1'b0;
      chk_idx_in   = scan_addr_ff;
      match_in     = match_ff;
      hi_in        = hi_ff;
      match_idx_in = match_idx_ff;
      pos_found_in = pos_found_ff;
      pos_in       = pos_ff;
      sh_in        = sh_ff;
      pend_in      = 1'b0;
      pend_dst_in  = sh_ff;
      acc_in       = acc_ff;
      ent_vld_in   = ent_vld_ff;
      rdent_in     = rdent_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = IW'(pos_ff);
      ram_wr_data  = ram_rd_data;
      ram_rd_addr  = IW'(scan_addr_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in       = req_payload;
               acc_in       = 1'b0;
               ent_vld_in   = 1'b0;
               scan_addr_in = '0;
               match_in     = 1'b0;
               hi_in        = 1'b0;
               pos_found_in = 1'b0;
               pos_in       = count_ff;
               case (req_payload.operation)
                  OP_OFFER: state_in = ST_SCAN;
                  OP_READ: begin
                     if (XW'(req_payload.rank_index) < XW'(count_ff)) begin
                        state_in = ST_FETCH;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = ST_RESP;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end

         ST_SCAN: begin
            // issue one row read a cycle, compare the row whose registered read came back
            if (scan_addr_ff < count_ff) begin
               chk_in       = 1'b1;
               scan_addr_in = scan_addr_ff + 1'b1;
            end
            if (chk_ff) begin
               if (!match_ff && ram_rd_data.key == req_ff.user_key) begin
                  match_in     = 1'b1;
                  match_idx_in = chk_idx_ff;
                  hi_in        = (ram_rd_data.score >= req_ff.score_value);
               end
               if (!pos_found_ff && ram_rd_data.score < req_ff.score_value) begin
                  pos_found_in = 1'b1;
                  pos_in       = chk_idx_ff;
               end
            end
            if (!(scan_addr_ff < count_ff) && !chk_ff) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            // a held key with an equal or higher score, or a full table that
            // all scores at least as high, turns the offer away
            if ((match_ff && hi_ff) ||
                (!match_ff && pos_ff == CW'(TABLE_DEPTH))) begin
               state_in = ST_RESP;
            end else begin
               sh_in = top_idx;
               if (!match_ff && count_ff < CW'(TABLE_DEPTH)) begin
                  count_in = count_ff + 1'b1;
               end
               state_in = ST_SHIFT;
            end
         end

         ST_SHIFT: begin
            // move rows down by one, from the top row towards the insert point
            ram_rd_addr = IW'(sh_ff - 1'b1);
            if (sh_ff > pos_ff) begin
               pend_in     = 1'b1;
               pend_dst_in = sh_ff;
               sh_in       = sh_ff - 1'b1;
            end
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = IW'(pend_dst_ff);
               ram_wr_data = ram_rd_data;
            end
            if (!(sh_ff > pos_ff) && !pend_ff) begin
               state_in = ST_PLACE;
            end
         end

         ST_PLACE: begin
            ram_wr_en         = 1'b1;
            ram_wr_addr       = IW'(pos_ff);
            ram_wr_data.key   = req_ff.user_key;
            ram_wr_data.score = req_ff.score_value;
            ram_wr_data.level = req_ff.level_value;
            ram_wr_data.stamp = req_ff.stamp_value;
            acc_in            = 1'b1;
            state_in          = ST_RESP;
         end

         ST_FETCH: begin
            ram_rd_addr = IW'(req_ff.rank_index);
            state_in    = ST_LOAD;
         end

         ST_LOAD: begin
            rdent_in   = ram_rd_data;
            ent_vld_in = 1'b1;
            state_in   = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.accepted     = acc_ff;
               rsp_in.insert_rank  = acc_ff ? RANK_W'(pos_ff) : '0;
               rsp_in.entry_count  = COUNT_W'(count_ff);
               rsp_in.entry_valid  = ent_vld_ff;
               rsp_in.entry_key    = ent_vld_ff ? rdent_ff.key   : '0;
               rsp_in.entry_score  = ent_vld_ff ? rdent_ff.score : '0;
               rsp_in.entry_level  = ent_vld_ff ? rdent_ff.level : '0;
               rsp_in.entry_stamp  = ent_vld_ff ? rdent_ff.stamp : '0;
               state_in            = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         chk_ff       <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_ff       <= chk_in;
         pend_ff      <= pend_in;
      end
   end

   // payload and per-request working registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      scan_addr_ff <= scan_addr_in;
      chk_idx_ff   <= chk_idx_in;
      match_ff     <= match_in;
      hi_ff        <= hi_in;
      match_idx_ff <= match_idx_in;
      pos_found_ff <= pos_found_in;
      pos_ff       <= pos_in;
      sh_ff        <= sh_in;
      pend_dst_ff  <= pend_dst_in;
      acc_ff       <= acc_in;
      ent_vld_ff   <= ent_vld_in;
      rdent_ff     <= rdent_in;
      rsp_ff       <= rsp_in;
   end

   // the entry count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // a new row is only ever placed inside the table
   a_place_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PLACE |-> pos_ff < CW'(TABLE_DEPTH))
      else $error("insert rank outside the table");

   // the move pass never runs below the insert point
   a_shift_above_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT |-> sh_ff >= pos_ff)
      else $error("move pass passed the insert point");

   // a fresh result only comes out of the result state
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result raised outside the result state");

   // an offer that grows the table was not a replacement of a held key
   a_grow_no_match: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DECIDE && count_in != count_ff |-> !match_ff)
      else $error("replacement changed the entry count");

endmodule

FILE: tb/sv/tb.sv
// self-checking testbench for the per-key top-n score table
module tb
   import bpt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH     = DEFAULT_TABLE_DEPTH;
   localparam int KEY_POOL  = 24;
   localparam int RANDOM_N  = 420;
   localparam int PAUSE_AT  = 210;
   localparam int DRAIN_CYC = 60;

   // operation code with no function
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   // one row of the directed plan: a request, how many times it repeats with
   // the key stepped each time, and a hand-written answer where one is known
   typedef struct {
      req_type req;
      int      reps;
      bit      fixed;
      rsp_type want;
   } plan_row_type;

   // what the sender knows about a request it is about to issue
   typedef struct {
      bit      fixed;
      rsp_type value;
   } answer_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // shadow copy of the ranked table, rows past the count are stale
   entry_type score_rows[DEPTH];
   int        rows_held = 0;

   answer_type answer_notes[$];
   rsp_type    due_results[$];
   int         failures = 0;

   // sender burst bookkeeping and receiver stall bookkeeping
   int          burst_left = 0;
   int          stall_left = 0;
   int unsigned rx_cycle   = 0;
   logic [KEY_W-1:0] key_pool[KEY_POOL];

   best_per_key_topn_table #(
      .TABLE_DEPTH(DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // synchronous reset, held at the start and then released
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // hard stop in case the block hangs
   initial begin
      #10ms;
      $display("== FAIL ==");
      $finish;
   end

   function automatic req_type mk_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                      logic [SCORE_W-1:0] score,
                                      logic [LEVEL_W-1:0] level,
                                      logic [STAMP_W-1:0] stamp,
                                      logic [RANK_W-1:0] rank);
      req_type r;
      r.operation   = op;
      r.user_key    = key;
      r.score_value = score;
      r.level_value = level;
      r.stamp_value = stamp;
      r.rank_index  = rank;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(logic acc, logic [RANK_W-1:0] rank,
                                      logic [COUNT_W-1:0] count, logic valid,
                                      logic [KEY_W-1:0] key,
                                      logic [SCORE_W-1:0] score,
                                      logic [LEVEL_W-1:0] level,
                                      logic [STAMP_W-1:0] stamp);
      rsp_type e;
      e.accepted    = acc;
      e.insert_rank = rank;
      e.entry_count = count;
      e.entry_valid = valid;
      e.entry_key   = key;
      e.entry_score = score;
      e.entry_level = level;
      e.entry_stamp = stamp;
      return e;
   endfunction

   // ranked insert with one entry per key, updates the shadow table
   function automatic rsp_type predict_request(req_type r);
      rsp_type e;
      int      hit;
      int      pos;
      int      q;
      bit      reject;
      e = '0;
      case (r.operation)
         OP_OFFER: begin
            reject = 1'b0;
            hit    = -1;
            for (q = 0; q < rows_held; q++) begin
               if (score_rows[q].key == r.user_key) begin
                  hit = q;
                  break;
               end
            end
            // same key already held: keep the better score only
            if (hit >= 0) begin
               if (score_rows[hit].score >= r.score_value) begin
                  reject = 1'b1;
               end else begin
                  for (q = hit; q + 1 < rows_held; q++) score_rows[q] = score_rows[q + 1];
                  rows_held--;
               end
            end
            if (!reject) begin
               // ties go behind the entries already there
               pos = 0;
               while (pos < rows_held && score_rows[pos].score >= r.score_value) pos++;
               if (pos < DEPTH) begin
                  if (rows_held >= DEPTH) rows_held = DEPTH - 1;
                  for (q = rows_held; q > pos; q--) score_rows[q] = score_rows[q - 1];
                  score_rows[pos].key   = r.user_key;
                  score_rows[pos].score = r.score_value;
                  score_rows[pos].level = r.level_value;
                  score_rows[pos].stamp = r.stamp_value;
                  rows_held++;
                  e.accepted    = 1'b1;
                  e.insert_rank = RANK_W'(pos);
               end
            end
         end
         OP_READ: begin
            if (int'(r.rank_index) < rows_held) begin
               e.entry_valid = 1'b1;
               e.entry_key   = score_rows[r.rank_index].key;
               e.entry_score = score_rows[r.rank_index].score;
               e.entry_level = score_rows[r.rank_index].level;
               e.entry_stamp = score_rows[r.rank_index].stamp;
            end
         end
         OP_CLEAR: rows_held = 0;
         default: ;
      endcase
      e.entry_count = COUNT_W'(rows_held);
      return e;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s expected %0h actual %0h", name, want, got);
         failures++;
      end
   endtask

   // random request: mostly offers on a small key pool so keys collide and
   // the table fills, with scores often small to force ties
   function automatic req_type random_request();
      req_type          r;
      int               pick;
      logic [OP_W-1:0]  op;
      logic [SCORE_W-1:0] score;
      logic [KEY_W-1:0] key;
      pick = $urandom_range(0, 99);
      if (pick < 62)      op = OP_OFFER;
      else if (pick < 93) op = OP_READ;
      else if (pick < 96) op = OP_CLEAR;
      else                op = OP_SPARE;
      key = ($urandom_range(0, 4) == 0) ? KEY_W'($urandom) :
            key_pool[$urandom_range(0, KEY_POOL - 1)];
      pick = $urandom_range(0, 9);
      if (pick < 5)       score = $urandom_range(0, 63);
      else if (pick < 8)  score = $urandom;
      else if (pick == 8) score = '1;
      else                score = '0;
      r = mk_req(op, key, score, LEVEL_W'($urandom), $urandom,
                 RANK_W'($urandom_range(0, DEPTH - 1)));
      return r;
   endfunction

   // ends a burst with a random gap; long bursts give stretches with no idling
   task automatic pace_sender();
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) :
                      $urandom_range(1, 12);
      end
      burst_left--;
   endtask

   task automatic send_request(req_type r, bit fixed, rsp_type want);
      answer_type note;
      note.fixed = fixed;
      note.value = want;
      answer_notes.push_back(note);
      req_payload <= r;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // request side: directed plan, then random traffic, then drain
   initial begin : sender
      plan_row_type plan[$];
      plan_row_type row;
      req_type      r;
      int           i;
      int           n;

      key_pool[0] = '0;
      key_pool[1] = '1;
      for (i = 2; i < KEY_POOL; i++) key_pool[i] = KEY_W'($urandom);

      // empty table after reset: read and the unused code report nothing
      plan.push_back('{mk_req(OP_READ, 0, 0, 0, 0, 0), 1, 1'b1, '0});
      plan.push_back('{mk_req(OP_SPARE, '1, '1, '1, '1, '1), 1, 1'b1, '0});
      // extreme entry goes first, all-zero entry behind it
      plan.push_back('{mk_req(OP_OFFER, '1, '1, '1, '1, 0), 1, 1'b1,
                       mk_rsp(1, 0, 1, 0, 0, 0, 0, 0)});
      plan.push_back('{mk_req(OP_OFFER, 0, 0, 0, 0, '1), 1, 1'b1,
                       mk_rsp(1, 1, 2, 0, 0, 0, 0, 0)});
      // key already held with higher, then with equal score: rejected
      plan.push_back('{mk_req(OP_OFFER, '1, 5, 1, 1, 0), 1, 1'b1,
                       mk_rsp(0, 0, 2, 0, 0, 0, 0, 0)});
      plan.push_back('{mk_req(OP_OFFER, 0, 0, 1, 1, 0), 1, 1'b1,
                       mk_rsp(0, 0, 2, 0, 0, 0, 0, 0)});
      // better score for a held key replaces the old entry
      plan.push_back('{mk_req(OP_OFFER, 0, 7, 8'h5a, 32'h1234_5678, 0), 1, 1'b1,
                       mk_rsp(1, 1, 2, 0, 0, 0, 0, 0)});
      plan.push_back('{mk_req(OP_READ, '1, '1, '1, '1, 1), 1, 1'b1,
                       mk_rsp(0, 0, 2, 1, 0, 7, 8'h5a, 32'h1234_5678)});
      plan.push_back('{mk_req(OP_READ, 0, 0, 0, 0, '1), 1, 1'b1,
                       mk_rsp(0, 0, 2, 0, 0, 0, 0, 0)});
      plan.push_back('{mk_req(OP_READ, 0, 0, 0, 0, 0), 1, 1'b1,
                       mk_rsp(0, 0, 2, 1, '1, '1, '1, '1)});
      plan.push_back('{mk_req(OP_CLEAR, '1, '1, '1, '1, '1), 1, 1'b1,
                       mk_rsp(0, 0, 0, 0, 0, 0, 0, 0)});
      // fill the table with equal scores, each landing behind the last
      plan.push_back('{mk_req(OP_OFFER, 16'h0100, 50, 3, 32'h0000_00aa, 0), DEPTH,
                       1'b0, '0});
      // full table all scoring as high: rejected
      plan.push_back('{mk_req(OP_OFFER, 16'h0200, 50, 4, 4, 0), 1, 1'b1,
                       mk_rsp(0, 0, 16, 0, 0, 0, 0, 0)});
      // full table, higher score: goes to the top, the last row drops off
      plan.push_back('{mk_req(OP_OFFER, 16'h0201, 51, 4, 4, 0), 1, 1'b1,
                       mk_rsp(1, 0, 16, 0, 0, 0, 0, 0)});
      plan.push_back('{mk_req(OP_READ, 0, 0, 0, 0, '1), 1, 1'b0, '0});

      while (reset) @(posedge clock);

      foreach (plan[p]) begin
         row = plan[p];
         r   = row.req;
         for (n = 0; n < row.reps; n++) begin
            pace_sender();
            send_request(r, row.fixed, row.want);
            r.user_key = r.user_key + 1'b1;
         end
      end

      for (i = 0; i < RANDOM_N; i++) begin
         // one hold-off until every result is home
         if (i == PAUSE_AT) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (due_results.size() != 0);
            burst_left = 0;
         end
         pace_sender();
         send_request(random_request(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (due_results.size() != 0);
      repeat (DRAIN_CYC) @(posedge clock);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // response side: long quiet stretches alternate with random stalls
   always @(posedge clock) begin
      rx_cycle++;
      if (rx_cycle[8]) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 15);
      end
   end

   // predict on each accepted request, check each accepted result in order
   always @(posedge clock) begin : monitor
      answer_type note;
      rsp_type    guess;
      rsp_type    want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            note  = answer_notes.pop_front();
            guess = predict_request(req_payload);
            due_results.push_back(note.fixed ? note.value : guess);
         end
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $error("result with no request outstanding: %0h", rsp_payload);
               failures++;
            end else begin
               want = due_results.pop_front();
               check_field("accepted",    64'(want.accepted),
                           64'(rsp_payload.accepted));
               check_field("insert_rank", 64'(want.insert_rank),
                           64'(rsp_payload.insert_rank));
               check_field("entry_count", 64'(want.entry_count),
                           64'(rsp_payload.entry_count));
               check_field("entry_valid", 64'(want.entry_valid),
                           64'(rsp_payload.entry_valid));
               check_field("entry_key",   64'(want.entry_key),
                           64'(rsp_payload.entry_key));
               check_field("entry_score", 64'(want.entry_score),
                           64'(rsp_payload.entry_score));
               check_field("entry_level", 64'(want.entry_level),
                           64'(rsp_payload.entry_level));
               check_field("entry_stamp", 64'(want.entry_stamp),
                           64'(rsp_payload.entry_stamp));
            end
         end
      end
   end

endmodule
